/* rtl/core/binary_morphology_3x3_stream_unit_defines.svh */
// Assertion macros shared by the 3x3 binary morphology stream unit.
// No dependencies; every user must have clk and arst_n in scope.
`ifndef BINARY_MORPHOLOGY_3X3_STREAM_UNIT_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_STREAM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define BM3_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define BM3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BM3_ASSERT_ALWAYS(lbl, cond, msg)
`define BM3_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/bm3_pkg.sv */
// Shared types and constants of the 3x3 binary morphology stream unit.
// No dependencies.
package bm3_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int CFG_W = 12;
	localparam int POS_W = 23;
	localparam int ROW_W = 11;
	// bit counter of the column remainder unit
	localparam int CNT_W = $clog2(POS_W + 1);

	// flag bits of one window position
	localparam int FLAG_WHITE = 0;
	localparam int FLAG_BLACK = 1;

	localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OP_MODE = 2'd2;

	localparam logic [1:0] MODE_OUTLINE = 2'd0;
	localparam logic [1:0] MODE_CORRODE = 2'd1;
	localparam logic [1:0] MODE_EXPAND = 2'd2;

	localparam logic [CFG_W-1:0] RST_WIDTH = 12'd1280;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd960;
	localparam logic [CFG_W-1:0] MIN_DIM = 12'd3;
	localparam logic [CFG_W-1:0] MAX_HEIGHT = 12'd2048;

	localparam logic [7:0] PIX_WHITE = 8'd255;
	localparam logic [7:0] PIX_BLACK = 8'd0;

	typedef struct packed {
		logic [ADDR_W-1:0] col;
		logic [1:0] flags;
		logic emit;
		logic border;
		logic last;
	} item_t;

	// line store entry: row two back in upper, row one back in lower
	typedef struct packed {
		logic [1:0] upper;
		logic [1:0] lower;
	} line_entry_t;

endpackage

/* rtl/core/bm3_line_store.sv */
// Line store memory holding two rows of pixel flags, with reset clearing pass
// and write-to-read forwarding. Depends on bm3_pkg and the defines header.
`include "binary_morphology_3x3_stream_unit_defines.svh"

module bm3_line_store
	import bm3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  line_entry_t       wr_data,
	output line_entry_t       rd_data,
	output logic              clr_busy
);

	line_entry_t       mem [MAX_WIDTH];
	line_entry_t       rd_q;
	line_entry_t       fwd_data_q;
	logic              fwd_q;
	logic [ADDR_W:0]   clr_cnt_q;

	assign clr_busy = (clr_cnt_q != (ADDR_W+1)'(MAX_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			fwd_q <= 1'b0;
		end else begin
			if (clr_busy)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			// same entry written this edge: the array read returns stale data
			if (rd_en)
				fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy)
			mem[clr_cnt_q[ADDR_W-1:0]] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

	`BM3_ASSERT_ALWAYS(a_no_read_in_clear, !(rd_en && clr_busy), "read during clearing pass")
	`BM3_ASSERT_ALWAYS(a_no_write_in_clear, !(wr_en && clr_busy), "write during clearing pass")

endmodule

/* rtl/core/bm3_ctrl.sv */
// Configuration registers, frame position counters and the column remainder
// unit run after a register write. Depends on bm3_pkg and the defines header.
`include "binary_morphology_3x3_stream_unit_defines.svh"

module bm3_ctrl
	import bm3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             command,
	input  logic [7:0]       pixel_value,
	input  logic             advance,
	output item_t            item,
	output logic             ignore,
	output logic             busy,
	output logic [1:0]       mode
);

	logic [CFG_W-1:0] width_q, height_q;
	logic [1:0]       mode_q;
	logic [CFG_W-1:0] eff_w, eff_h, w_m1, h_m1;
	logic [POS_W-1:0] area_q;
	logic [POS_W-1:0] pos_q;
	logic [ADDR_W-1:0] col_q;
	logic [ROW_W-1:0] orow_q, ocol_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [CFG_W-1:0] rem_q;
	logic [CNT_W-1:0] bit_idx;
	logic [CFG_W:0]   rem_sh, rem_sub;
	logic [CFG_W-1:0] rem_n;
	logic             in_frame, col_end, ocol_end, orow_end;

	always_comb begin
		eff_w = width_q;
		if (width_q < MIN_DIM)
			eff_w = MIN_DIM;
		else if (width_q > CFG_W'(MAX_WIDTH))
			eff_w = CFG_W'(MAX_WIDTH);
		eff_h = height_q;
		if (height_q < MIN_DIM)
			eff_h = MIN_DIM;
		else if (height_q > MAX_HEIGHT)
			eff_h = MAX_HEIGHT;
	end

	assign w_m1 = eff_w - 1'b1;
	assign h_m1 = eff_h - 1'b1;
	assign mode = mode_q;
	assign busy = (div_cnt_q != '0);

	// restoring remainder step: pos mod width, one position bit per cycle
	assign bit_idx = div_cnt_q - 1'b1;
	assign rem_sh = {rem_q, pos_q[bit_idx]};
	assign rem_sub = rem_sh - {1'b0, eff_w};
	assign rem_n = (rem_sh >= {1'b0, eff_w}) ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];

	assign in_frame = (pos_q < area_q);
	assign col_end = ({1'b0, col_q} >= w_m1);
	assign ocol_end = ({1'b0, ocol_q} >= w_m1);
	assign orow_end = ({1'b0, orow_q} >= h_m1);

	always_comb begin
		ignore = command && (pos_q == '0);
		item.col = col_q;
		item.flags = '0;
		if (!command && in_frame) begin
			item.flags[FLAG_WHITE] = (pixel_value == PIX_WHITE);
			item.flags[FLAG_BLACK] = (pixel_value == PIX_BLACK);
		end
		item.emit = (pos_q >= (POS_W'(eff_w) + 1'b1));
		item.border = (orow_q == '0) || orow_end || (ocol_q == '0) || ocol_end;
		item.last = orow_end && ocol_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			mode_q <= MODE_OUTLINE;
			area_q <= '0;
			pos_q <= '0;
			col_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			div_cnt_q <= '0;
			rem_q <= '0;
		end else begin
			area_q <= POS_W'(eff_w) * POS_W'(eff_h);
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_FRAME_WIDTH:  width_q <= cfg_wdata;
					REG_FRAME_HEIGHT: height_q <= cfg_wdata;
					REG_OP_MODE:      mode_q <= cfg_wdata[1:0];
					default: ;
				endcase
				// restart the column recompute; area settles within it too
				div_cnt_q <= CNT_W'(POS_W);
				rem_q <= '0;
			end else if (busy) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				rem_q <= rem_n;
				if (div_cnt_q == CNT_W'(1))
					col_q <= rem_n[ADDR_W-1:0];
			end else if (advance) begin
				if (item.emit && item.last) begin
					pos_q <= '0;
					col_q <= '0;
					orow_q <= '0;
					ocol_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
					col_q <= col_end ? '0 : col_q + 1'b1;
					if (item.emit) begin
						if (ocol_end) begin
							ocol_q <= '0;
							orow_q <= orow_q + 1'b1;
						end else begin
							ocol_q <= ocol_q + 1'b1;
						end
					end
				end
			end
		end
	end

	`BM3_ASSERT_ALWAYS(a_no_advance_busy, !(advance && busy), "beat taken during recompute")
	`BM3_ASSERT_ALWAYS(a_col_in_range, busy || ({1'b0, col_q} < eff_w), "column out of range")

endmodule

/* rtl/core/bm3_window.sv */
// 3x3 flag window, decision logic and output register; drives line store
// write-back. Depends on bm3_pkg and the defines header.
`include "binary_morphology_3x3_stream_unit_defines.svh"

module bm3_window
	import bm3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  item_t             item,
	input  line_entry_t       rd_data,
	input  logic [1:0]        mode,
	input  logic              out_stall,
	output logic              s1_ready,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output line_entry_t       wr_data,
	output logic              out_valid,
	output logic [7:0]        out_pixel,
	output logic              frame_last
);

	item_t s1_q;
	logic  s1_valid_q;
	logic  s1_adv;
	logic [2:0][2:0][1:0] win_q, win_n;
	logic  out_valid_q, last_q;
	logic [7:0] pixel_q, pix_n;
	logic  c_white, c_black, n_white, n_black;

	assign s1_adv = s1_valid_q && (!s1_q.emit || !out_valid_q || !out_stall);
	assign s1_ready = !s1_valid_q || s1_adv;

	assign wr_en = s1_adv;
	assign wr_addr = s1_q.col;
	assign wr_data = '{upper: rd_data.lower, lower: s1_q.flags};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r][0] = win_q[r][1];
			win_n[r][1] = win_q[r][2];
		end
		win_n[0][2] = rd_data.upper;
		win_n[1][2] = rd_data.lower;
		win_n[2][2] = s1_q.flags;
	end

	always_comb begin
		n_white = 1'b0;
		n_black = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1)) begin
					n_white = n_white | win_n[r][c][FLAG_WHITE];
					n_black = n_black | win_n[r][c][FLAG_BLACK];
				end
			end
		end
		c_white = win_n[1][1][FLAG_WHITE];
		c_black = win_n[1][1][FLAG_BLACK];
		case (mode)
			MODE_CORRODE:
				pix_n = (s1_q.border || c_white || n_white) ? PIX_WHITE : PIX_BLACK;
			MODE_EXPAND:
				pix_n = (!s1_q.border && (c_black || n_black)) ? PIX_BLACK : PIX_WHITE;
			default:
				pix_n = (!s1_q.border && !c_white && n_white) ? PIX_WHITE : PIX_BLACK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			win_q <= '0;
		end else begin
			if (s1_ready)
				s1_valid_q <= load;
			if (s1_adv)
				win_q <= win_n;
			if (s1_adv && s1_q.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && load)
			s1_q <= item;
		if (s1_adv && s1_q.emit) begin
			pixel_q <= pix_n;
			last_q <= s1_q.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = pixel_q;
	assign frame_last = last_q;

	`BM3_ASSERT_NEXT(a_emit_loads_out, s1_adv && s1_q.emit, out_valid_q, "result lost")
	`BM3_ASSERT_ALWAYS(a_pixel_binary, !out_valid_q || pixel_q == PIX_WHITE || pixel_q == PIX_BLACK, "non-binary result")
	`BM3_ASSERT_ALWAYS(a_load_when_ready, !load || s1_ready, "item loaded while stage full")

endmodule

/* rtl/core/binary_morphology_3x3_stream_unit.sv */
// 3x3 binary morphology stream unit: one beat per clock sustained while in_stall is low.
// A result reaches the output register once the beat that completes its
// neighborhood has passed the line store read, then window and decision.
// After reset in_stall stays high while the line store clears all 2048 entries;
// every register write stalls input while the column is recomputed.
// Depends on bm3_pkg, bm3_ctrl, bm3_line_store and bm3_window.
module binary_morphology_3x3_stream_unit
	import bm3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [7:0]       pixel_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_pixel,
	output logic             frame_last
);

	item_t             item;
	logic              ignore, ctrl_busy, clr_busy, s1_ready;
	logic [1:0]        mode;
	logic              accept, load;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	line_entry_t       wr_data, rd_data;

	assign in_stall = ctrl_busy || clr_busy || !s1_ready;
	assign accept = in_valid && !in_stall;
	// an idle flush is taken and dropped
	assign load = accept && !ignore;

	bm3_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.command     (command),
		.pixel_value (pixel_value),
		.advance     (load),
		.item        (item),
		.ignore      (ignore),
		.busy        (ctrl_busy),
		.mode        (mode)
	);

	bm3_line_store u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (load),
		.rd_addr  (item.col),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	bm3_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.item       (item),
		.rd_data    (rd_data),
		.mode       (mode),
		.out_stall  (out_stall),
		.s1_ready   (s1_ready),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (out_valid),
		.out_pixel  (out_pixel),
		.frame_last (frame_last)
	);

endmodule

/* test/tb_binary_morphology_3x3_stream_unit.sv */
// Testbench for binary_morphology_3x3_stream_unit: a directed table, then random frames.
// Directed results are checked against the table, all others against a model of the
// line stores and window kept here. Depends on bm3_pkg and the unit itself.
module tb_binary_morphology_3x3_stream_unit
	import bm3_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HEIGHT_CAP = 2048;
	localparam int RANDOM_BEATS = 700;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD = 300;
	localparam int REPORT_LIMIT = 100;
	localparam int DIRECTED_LEN = 29;
	localparam int WIDE_BREAK = 60;
	localparam int TALL_BREAK = 300;
	localparam int TALL_HOLD = 100;

	typedef struct packed {
		logic [7:0] pix;
		logic is_last;
	} morph_result_t;

	typedef enum logic {ROW_BEAT, ROW_MODE} row_kind_t;

	// a mode row carries the mode in pix and reprograms a 3x3 frame
	typedef struct packed {
		row_kind_t kind;
		logic cmd;
		logic [7:0] pix;
		logic checked;
		logic [7:0] exp_pix;
		logic exp_last;
	} directed_row_t;

	localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
		'{ROW_MODE, CMD_PIXEL, {6'd0, MODE_OUTLINE}, 1'b0, PIX_BLACK, 1'b0},
		// flush with no frame open: ignored
		'{ROW_BEAT, CMD_FLUSH, PIX_WHITE, 1'b0, PIX_BLACK, 1'b0},
		// outline of a black dot on white: only the center lights up
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_FLUSH, PIX_BLACK, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_FLUSH, PIX_BLACK, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_FLUSH, PIX_BLACK, 1'b1, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_FLUSH, PIX_BLACK, 1'b1, PIX_BLACK, 1'b1},
		// corrode an all black frame: border white, center black
		'{ROW_MODE, CMD_PIXEL, {6'd0, MODE_CORRODE}, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b0, PIX_BLACK, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_BLACK, 1'b1, PIX_BLACK, 1'b0},
		// white pixels past the frame end count as padding
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_WHITE, 1'b0},
		'{ROW_BEAT, CMD_PIXEL, PIX_WHITE, 1'b1, PIX_WHITE, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [7:0] pixel_value;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_pixel;
	logic frame_last;

	// model state
	logic [CFG_W-1:0] cur_width;
	logic [CFG_W-1:0] cur_height;
	logic [1:0] cur_mode;
	logic [1:0] row_two_back [MAX_WIDTH];
	logic [1:0] row_one_back [MAX_WIDTH];
	logic [1:0] nbhd [3][3];
	logic [POS_W-1:0] feed_pos;
	logic [ROW_W-1:0] emit_row;
	logic [ROW_W-1:0] emit_col;

	morph_result_t pending_results [$];
	int mismatch_count = 0;
	int max_gap = 5;
	int beats_sent = 0;
	bit hold_off_req = 1'b0;

	binary_morphology_3x3_stream_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_pixel(out_pixel),
		.frame_last(frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_width();
		int w;
		w = int'(cur_width);
		if (w < int'(MIN_DIM)) w = int'(MIN_DIM);
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int active_height();
		int h;
		h = int'(cur_height);
		if (h < int'(MIN_DIM)) h = int'(MIN_DIM);
		if (h > HEIGHT_CAP) h = HEIGHT_CAP;
		return h;
	endfunction

	// Advance the window by one beat; returns 1 when the beat completes a result.
	function automatic bit predict_morph_beat(input logic cmd, input logic [7:0] pix,
			output morph_result_t res);
		int w, h, col, r, c;
		logic [1:0] f;
		logic any_white, any_black, border, emit;

		w = active_width();
		h = active_height();
		res = '0;
		if (cmd == CMD_FLUSH && feed_pos == 0)
			return 1'b0;

		col = feed_pos % w;
		f = 2'b00;
		if (cmd == CMD_PIXEL && feed_pos < w * h) begin
			if (pix == PIX_WHITE)
				f[FLAG_WHITE] = 1'b1;
			else if (pix == PIX_BLACK)
				f[FLAG_BLACK] = 1'b1;
		end

		for (r = 0; r < 3; r++) begin
			nbhd[r][0] = nbhd[r][1];
			nbhd[r][1] = nbhd[r][2];
		end
		nbhd[0][2] = row_two_back[col];
		nbhd[1][2] = row_one_back[col];
		nbhd[2][2] = f;
		row_two_back[col] = row_one_back[col];
		row_one_back[col] = f;

		emit = feed_pos >= w + 1;
		feed_pos = feed_pos + 1'b1;
		if (!emit)
			return 1'b0;

		any_white = 1'b0;
		any_black = 1'b0;
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				if (r != 1 || c != 1) begin
					any_white |= nbhd[r][c][FLAG_WHITE];
					any_black |= nbhd[r][c][FLAG_BLACK];
				end
			end
		end
		border = emit_row == 0 || emit_row >= h - 1 || emit_col == 0 || emit_col >= w - 1;
		res.is_last = emit_row >= h - 1 && emit_col >= w - 1;

		case (cur_mode)
			MODE_CORRODE: begin
				res.pix = (border || nbhd[1][1][FLAG_WHITE] || any_white) ? PIX_WHITE : PIX_BLACK;
			end
			MODE_EXPAND: begin
				if (border)
					res.pix = PIX_WHITE;
				else
					res.pix = (nbhd[1][1][FLAG_BLACK] || any_black) ? PIX_BLACK : PIX_WHITE;
			end
			default: begin
				// unused mode falls back to outline
				if (border || nbhd[1][1][FLAG_WHITE])
					res.pix = PIX_BLACK;
				else
					res.pix = any_white ? PIX_WHITE : PIX_BLACK;
			end
		endcase

		if (res.is_last) begin
			feed_pos = '0;
			emit_row = '0;
			emit_col = '0;
		end else if (emit_col >= w - 1) begin
			emit_col = '0;
			emit_row = emit_row + 1'b1;
		end else begin
			emit_col = emit_col + 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return PIX_WHITE;
			4, 5, 6, 7: return PIX_BLACK;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic pick_config(output logic [CFG_W-1:0] w, output logic [CFG_W-1:0] h,
			output logic [1:0] m);
		case ($urandom_range(0, 9))
			0: w = CFG_W'($urandom_range(0, 2));
			1: w = CFG_W'($urandom_range(13, 48));
			default: w = CFG_W'($urandom_range(3, 12));
		endcase
		h = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 8));
		m = 2'($urandom_range(MODE_OUTLINE, MODE_UNUSED));
	endtask

	// Drain the pipeline, then program all three registers back to back.
	task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [1:0] m);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_FRAME_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_addr <= REG_FRAME_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_addr <= REG_OP_MODE;
		cfg_wdata <= {{(CFG_W-2){1'b0}}, m};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_width = w;
		cur_height = h;
		cur_mode = m;
	endtask

	task automatic send_beat(input logic cmd, input logic [7:0] pix, input logic typed,
			input morph_result_t want);
		int gap;
		morph_result_t res;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pixel_value <= pix;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (predict_morph_beat(cmd, pix, res))
			pending_results.push_back(typed ? want : res);
	endtask

	// Run the current frame to its end; optionally reprogram or hold the output mid-frame.
	task automatic run_frame(input int break_at, input logic [CFG_W-1:0] bw,
			input logic [CFG_W-1:0] bh, input logic [1:0] bm, input int hold_at);
		int n;
		logic cmd;
		n = 0;
		do begin
			if (n == break_at)
				set_config(bw, bh, bm);
			if (n == hold_at)
				hold_off_req = 1'b1;
			if (n == 0)
				cmd = CMD_PIXEL;
			else if (feed_pos < active_width() * active_height())
				cmd = ($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_PIXEL;
			else
				cmd = ($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH;
			send_beat(cmd, rand_pixel(), 1'b0, '0);
			n++;
		end while (feed_pos != 0);
		beats_sent += n;
	endtask

	initial begin : stimulus
		int i, r, c, phase, frames, f, break_at;
		logic [CFG_W-1:0] w, h, bw, bh;
		logic [1:0] m, bm;
		directed_row_t row;
		morph_result_t want;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= REG_FRAME_WIDTH;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_PIXEL;
		pixel_value <= '0;

		cur_width = RST_WIDTH;
		cur_height = RST_HEIGHT;
		cur_mode = MODE_OUTLINE;
		for (i = 0; i < MAX_WIDTH; i++) begin
			row_two_back[i] = 2'b00;
			row_one_back[i] = 2'b00;
		end
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				nbhd[r][c] = 2'b00;
		feed_pos = '0;
		emit_row = '0;
		emit_col = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_LEN; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_MODE) begin
				set_config(MIN_DIM, MIN_DIM, row.pix[1:0]);
			end else begin
				want.pix = row.exp_pix;
				want.is_last = row.exp_last;
				send_beat(row.cmd, row.pix, row.checked, want);
			end
		end

		beats_sent = 0;
		phase = 0;
		while (beats_sent < RANDOM_BEATS) begin
			pick_config(w, h, m);
			set_config(w, h, m);
			// some phases run flat out on both sides
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				if ($urandom_range(0, 3) == 0)
					send_beat(CMD_FLUSH, rand_pixel(), 1'b0, '0);
				break_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : -1;
				pick_config(bw, bh, bm);
				run_frame(break_at, bw, bh, bm, (phase == 2 && f == 0) ? 10 : -1);
			end
			phase++;
		end

		// widest frame, width above range; narrow it mid-frame to end the frame early
		max_gap = 5;
		m = 2'($urandom_range(MODE_OUTLINE, MODE_UNUSED));
		set_config({CFG_W{1'b1}}, MIN_DIM, m);
		run_frame(WIDE_BREAK, CFG_W'(5), MIN_DIM, m, -1);

		// tallest frame, height above range; hold the output, then cut the frame short
		m = 2'($urandom_range(MODE_OUTLINE, MODE_UNUSED));
		set_config(MIN_DIM, {CFG_W{1'b1}}, m);
		run_frame(TALL_BREAK, MIN_DIM, CFG_W'(5), m, TALL_HOLD);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_check
		int stall_cycles;
		morph_result_t want;

		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			stall_cycles = hold_off_req ? LONG_HOLD : $urandom_range(0, max_gap);
			hold_off_req = 1'b0;
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);

			if (pending_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: unexpected beat, expected none, got out_pixel %0d frame_last %0b",
						$time, out_pixel, frame_last);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_pixel !== want.pix) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: out_pixel expected %0d, got %0d",
							$time, want.pix, out_pixel);
					mismatch_count++;
				end
				if (frame_last !== want.is_last) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: frame_last expected %0b, got %0b",
							$time, want.is_last, frame_last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* binary_morphology_3x3_stream_unit.f */
+incdir+rtl/core
rtl/core/bm3_pkg.sv
rtl/core/bm3_line_store.sv
rtl/core/bm3_ctrl.sv
rtl/core/bm3_window.sv
rtl/core/binary_morphology_3x3_stream_unit.sv
test/tb_binary_morphology_3x3_stream_unit.sv
